### sv/cbd_pkg.sv
`timescale 1ns / 1ps

package cbd_pkg;

  // default widths of the body length limit and of the consumed byte counter
  localparam int unsigned LIMIT_BITS_DEF = 24;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // reset value of the body length limit
  localparam logic [63:0] MAX_BODY_RESET = 64'd1048576;

  // queue depths between the stages
  localparam int unsigned FRONT_DEPTH = 4;
  localparam int unsigned OUTQ_DEPTH  = 2;

  // characters the parser looks for
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_INVALID = 2'd2
  } kind_t;

  // one classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       is_cr;
    logic       is_lf;
    logic       is_semi;
    logic       is_blank;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  // sort a raw byte into the classes the size line parser needs
  function automatic item_t classify(input logic [7:0] c, input logic start);
    item_t r;
    logic [7:0] off;
    r.data     = c;
    r.start    = start;
    r.is_cr    = (c == CH_CR);
    r.is_lf    = (c == CH_LF);
    r.is_semi  = (c == CH_SEMI);
    r.is_blank = (c == CH_SPACE) || (c == CH_TAB);
    r.is_hex   = 1'b0;
    r.hex_val  = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      off       = c - CH_0;
      r.is_hex  = 1'b1;
      r.hex_val = off[3:0];
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      off       = c - CH_LA + 8'd10;
      r.is_hex  = 1'b1;
      r.hex_val = off[3:0];
    end else if (c >= CH_UA && c <= CH_UF) begin
      off       = c - CH_UA + 8'd10;
      r.is_hex  = 1'b1;
      r.hex_val = off[3:0];
    end
    return r;
  endfunction

endpackage

### sv/cbd_front.sv
`timescale 1ns / 1ps

module cbd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [7:0]     byte_in,
  input  logic           start_req,
  output logic           full,
  output logic           item_valid,
  output cbd_pkg::item_t item,
  input  logic           item_take
);

  localparam int unsigned DEPTH = cbd_pkg::FRONT_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cbd_pkg::item_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  // handshake on both sides of the queue
  assign full       = (count == CNT_W'(DEPTH));
  assign item_valid = (count != '0);
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;
  assign item       = store[rd_ptr];

  // classify on entry and store the beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= cbd_pkg::classify(byte_in, start_req);
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/cbd_back.sv
`timescale 1ns / 1ps

module cbd_back #(
  parameter int unsigned LIMIT_BITS = cbd_pkg::LIMIT_BITS_DEF,
  parameter int unsigned COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LIMIT_BITS-1:0] cfg_data,
  input  logic                  item_valid,
  input  cbd_pkg::item_t        item,
  output logic                  item_take,
  input  logic                  res_full,
  output logic                  res_push,
  output cbd_pkg::kind_t        res_kind,
  output logic [7:0]            res_payload,
  output logic [COUNT_BITS-1:0] res_consumed,
  output logic [LIMIT_BITS-1:0] res_body_len
);

  localparam int unsigned SIZE_W = LIMIT_BITS + 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIZE,
    PH_SIZE_CR,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TRAILER
  } phase_t;

  logic [LIMIT_BITS-1:0] max_bytes;
  phase_t                phase, phase_b, phase_next;
  logic [SIZE_W-1:0]     size, size_b, size_next;
  logic                  f_digit, f_digit_b, f_digit_next;
  logic                  f_trail, f_trail_b, f_trail_next;
  logic                  f_ext, f_ext_b, f_ext_next;
  logic                  f_bad, f_bad_b, f_bad_next;
  logic [LIMIT_BITS-1:0] total, total_b, total_next;
  logic [COUNT_BITS-1:0] count, count_b, count_next;
  logic [1:0]            tm, tm_b, tm_next;
  logic [LIMIT_BITS+1:0] sum;
  logic                  emit;
  logic                  want_lf;

  assign item_take = item_valid && !res_full;

  // start flag clears the parser before the byte is applied
  always_comb begin
    if (item.start) begin
      phase_b   = PH_SIZE;
      size_b    = '0;
      f_digit_b = 1'b0;
      f_trail_b = 1'b0;
      f_ext_b   = 1'b0;
      f_bad_b   = 1'b0;
      total_b   = '0;
      count_b   = '0;
      tm_b      = '0;
    end else begin
      phase_b   = phase;
      size_b    = size;
      f_digit_b = f_digit;
      f_trail_b = f_trail;
      f_ext_b   = f_ext;
      f_bad_b   = f_bad;
      total_b   = total;
      count_b   = count;
      tm_b      = tm;
    end
  end

  // limit check: running total plus announced size
  assign sum     = {2'b00, total_b} + {1'b0, size_b};
  assign want_lf = tm_b[0];

  // parser step for one byte
  always_comb begin
    phase_next   = phase_b;
    size_next    = size_b;
    f_digit_next = f_digit_b;
    f_trail_next = f_trail_b;
    f_ext_next   = f_ext_b;
    f_bad_next   = f_bad_b;
    total_next   = total_b;
    count_next   = count_b;
    tm_next      = tm_b;
    emit         = 1'b0;
    res_kind     = cbd_pkg::KIND_PAYLOAD;
    res_payload  = '0;
    res_consumed = '0;

    if (phase_b != PH_IDLE && count_b != '1) begin
      count_next = count_b + 1'b1;
    end

    case (phase_b)
      PH_SIZE: begin
        if (item.is_cr) begin
          phase_next = PH_SIZE_CR;
        end else if (!f_ext_b) begin
          if (item.is_semi) begin
            f_ext_next = 1'b1;
          end else if (item.is_blank) begin
            if (f_digit_b) f_trail_next = 1'b1;
          end else if (!item.is_hex || f_trail_b) begin
            f_bad_next = 1'b1;
          end else begin
            f_digit_next = 1'b1;
            if (|size_b[SIZE_W-1:SIZE_W-4]) begin
              size_next = '1;
            end else begin
              size_next = {size_b[SIZE_W-5:0], item.hex_val};
            end
          end
        end
      end
      PH_SIZE_CR: begin
        if (!item.is_lf) begin
          f_bad_next = 1'b1;
          if (!item.is_cr) phase_next = PH_SIZE;
        end else if (f_bad_b || !f_digit_b) begin
          emit     = 1'b1;
          res_kind = cbd_pkg::KIND_INVALID;
        end else if (size_b == '0) begin
          phase_next = PH_TRAILER;
          tm_next    = 2'd2;
        end else if (sum > {2'b00, max_bytes}) begin
          emit     = 1'b1;
          res_kind = cbd_pkg::KIND_INVALID;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        size_next = size_b - 1'b1;
        if (total_b != '1) total_next = total_b + 1'b1;
        if (size_b == SIZE_W'(1)) phase_next = PH_DATA_CR;
        emit        = 1'b1;
        res_payload = item.data;
      end
      PH_DATA_CR: begin
        if (!item.is_cr) begin
          emit     = 1'b1;
          res_kind = cbd_pkg::KIND_INVALID;
        end else begin
          phase_next = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (!item.is_lf) begin
          emit     = 1'b1;
          res_kind = cbd_pkg::KIND_INVALID;
        end else begin
          phase_next   = PH_SIZE;
          size_next    = '0;
          f_digit_next = 1'b0;
          f_trail_next = 1'b0;
          f_ext_next   = 1'b0;
          f_bad_next   = 1'b0;
        end
      end
      PH_TRAILER: begin
        // track progress through CR LF CR LF
        if ((want_lf && item.is_lf) || (!want_lf && item.is_cr)) begin
          if (tm_b == 2'd3) begin
            emit         = 1'b1;
            res_kind     = cbd_pkg::KIND_DONE;
            res_consumed = count_next;
          end else begin
            tm_next = tm_b + 1'b1;
          end
        end else begin
          tm_next = item.is_cr ? 2'd1 : 2'd0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (emit && res_kind != cbd_pkg::KIND_PAYLOAD) begin
      phase_next = PH_IDLE;
    end
  end

  assign res_push     = item_take && emit;
  assign res_body_len = total_next;

  // parser state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= LIMIT_BITS'(cbd_pkg::MAX_BODY_RESET);
      phase     <= PH_IDLE;
      size      <= '0;
      f_digit   <= 1'b0;
      f_trail   <= 1'b0;
      f_ext     <= 1'b0;
      f_bad     <= 1'b0;
      total     <= '0;
      count     <= '0;
      tm        <= '0;
    end else begin
      if (cfg_we) begin
        max_bytes <= cfg_data;
      end
      if (item_take) begin
        phase   <= phase_next;
        size    <= size_next;
        f_digit <= f_digit_next;
        f_trail <= f_trail_next;
        f_ext   <= f_ext_next;
        f_bad   <= f_bad_next;
        total   <= total_next;
        count   <= count_next;
        tm      <= tm_next;
      end
    end
  end

endmodule

### sv/cbd_outq.sv
`timescale 1ns / 1ps

module cbd_outq #(
  parameter int unsigned LIMIT_BITS = cbd_pkg::LIMIT_BITS_DEF,
  parameter int unsigned COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_push,
  input  cbd_pkg::kind_t        res_kind,
  input  logic [7:0]            res_payload,
  input  logic [COUNT_BITS-1:0] res_consumed,
  input  logic [LIMIT_BITS-1:0] res_body_len,
  output logic                  res_full,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            kind,
  output logic [7:0]            payload,
  output logic [COUNT_BITS-1:0] consumed_count,
  output logic [LIMIT_BITS-1:0] body_length
);

  localparam int unsigned DEPTH = cbd_pkg::OUTQ_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cbd_pkg::kind_t        q_kind [DEPTH];
  logic [7:0]            q_pay  [DEPTH];
  logic [COUNT_BITS-1:0] q_cons [DEPTH];
  logic [LIMIT_BITS-1:0] q_len  [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  rd_en;

  assign res_full       = (count == CNT_W'(DEPTH));
  assign empty          = (count == '0);
  assign rd_en          = pop && !empty;
  assign kind           = q_kind[rd_ptr];
  assign payload        = q_pay[rd_ptr];
  assign consumed_count = q_cons[rd_ptr];
  assign body_length    = q_len[rd_ptr];

  // result storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      q_kind[wr_ptr] <= res_kind;
      q_pay[wr_ptr]  <= res_payload;
      q_cons[wr_ptr] <= res_consumed;
      q_len[wr_ptr]  <= res_body_len;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (res_push && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !res_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/chunked_body_decoder.sv
`timescale 1ns / 1ps

// Streaming decoder for an HTTP chunked transfer body, one encoded byte per beat.
// Input side is a queue: a beat (byte_in, start_req) is taken when push is high
// and full is low. start_req marks the first byte of a new body and clears the
// parser. Result side is a queue: while empty is low the oldest result sits on
// kind, payload, consumed_count and body_length; pop takes it. kind is a payload
// byte, body complete (consumed_count valid) or body invalid; after complete or
// invalid the decoder ignores bytes until the next start_req.
// A byte accepted into the input queue is parsed once it reaches the head and the
// result queue has room; its result is then registered there, where pop takes it.
// Throughput: one byte per cycle while the result queue has room; the parser
// state register closes the loop. A four-beat input queue and a two-beat result
// queue part the sides, so input keeps flowing while a result waits, and stops
// only when both fill up under a stalled receiver.
// The limit register is written over cfg_valid/cfg_ready (always ready); the user
// must write it only while the decoder is idle (not enforced). Reset empties both
// queues, idles the parser, sets the limit to 1048576; no clearing pass is needed.
module chunked_body_decoder #(
  parameter int unsigned LIMIT_BITS = cbd_pkg::LIMIT_BITS_DEF,
  parameter int unsigned COUNT_BITS = cbd_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            byte_in,
  input  logic                  start_req,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            kind,
  output logic [7:0]            payload,
  output logic [COUNT_BITS-1:0] consumed_count,
  output logic [LIMIT_BITS-1:0] body_length,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_BITS-1:0] cfg_data
);

  cbd_pkg::item_t        item;
  logic                  item_valid;
  logic                  item_take;
  logic                  res_full;
  logic                  res_push;
  cbd_pkg::kind_t        res_kind;
  logic [7:0]            res_payload;
  logic [COUNT_BITS-1:0] res_consumed;
  logic [LIMIT_BITS-1:0] res_body_len;

  assign cfg_ready = 1'b1;

  // byte classification and input queue
  cbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .byte_in    (byte_in),
    .start_req  (start_req),
    .full       (full),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // chunk parser
  cbd_back #(
    .LIMIT_BITS (LIMIT_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_kind     (res_kind),
    .res_payload  (res_payload),
    .res_consumed (res_consumed),
    .res_body_len (res_body_len)
  );

  // result queue
  cbd_outq #(
    .LIMIT_BITS (LIMIT_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_outq (
    .clk            (clk),
    .rst            (rst),
    .res_push       (res_push),
    .res_kind       (res_kind),
    .res_payload    (res_payload),
    .res_consumed   (res_consumed),
    .res_body_len   (res_body_len),
    .res_full       (res_full),
    .empty          (empty),
    .pop            (pop),
    .kind           (kind),
    .payload        (payload),
    .consumed_count (consumed_count),
    .body_length    (body_length)
  );

endmodule
